// File: src/mbsp_pkg.sv
// ---------------------------------------------------------------------------
// MIDI byte stream parser package
// Event kinds, status codes and the event record shared by the parser files.
// ---------------------------------------------------------------------------
`default_nettype none

package mbsp_pkg;

    typedef enum logic [4:0] {
        KIND_NOTE_OFF    = 5'd0,
        KIND_NOTE_ON     = 5'd1,
        KIND_POLY_PRESS  = 5'd2,
        KIND_CONTROL     = 5'd3,
        KIND_PROGRAM     = 5'd4,
        KIND_CHAN_PRESS  = 5'd5,
        KIND_BEND        = 5'd6,
        KIND_SYSEX       = 5'd7,
        KIND_TIME_CODE   = 5'd8,
        KIND_SONG_POS    = 5'd9,
        KIND_SONG_SEL    = 5'd10,
        KIND_RESERVED    = 5'd11,
        KIND_TUNE        = 5'd12,
        KIND_CLOCK       = 5'd13,
        KIND_START       = 5'd14,
        KIND_CONTINUE    = 5'd15,
        KIND_STOP        = 5'd16,
        KIND_RESET       = 5'd17,
        KIND_BUFFER_FULL = 5'd18
    } mbsp_kind_t;

    localparam logic [7:0] STATUS_NONE      = 8'h00;
    localparam logic [7:0] STATUS_NOTE_OFF  = 8'h80;
    localparam logic [7:0] STATUS_NOTE_ON   = 8'h90;
    localparam logic [7:0] STATUS_POLY      = 8'hA0;
    localparam logic [7:0] STATUS_CONTROL   = 8'hB0;
    localparam logic [7:0] STATUS_PROGRAM   = 8'hC0;
    localparam logic [7:0] STATUS_CHAN_PRS  = 8'hD0;
    localparam logic [7:0] STATUS_BEND      = 8'hE0;
    localparam logic [7:0] STATUS_SYSEX     = 8'hF0;
    localparam logic [7:0] STATUS_TIME_CODE = 8'hF1;
    localparam logic [7:0] STATUS_SONG_POS  = 8'hF2;
    localparam logic [7:0] STATUS_SONG_SEL  = 8'hF3;
    localparam logic [7:0] STATUS_RSV_F4    = 8'hF4;
    localparam logic [7:0] STATUS_RSV_F5    = 8'hF5;
    localparam logic [7:0] STATUS_TUNE      = 8'hF6;
    localparam logic [7:0] STATUS_CLOCK     = 8'hF8;
    localparam logic [7:0] STATUS_RSV_F9    = 8'hF9;
    localparam logic [7:0] STATUS_START     = 8'hFA;
    localparam logic [7:0] STATUS_CONTINUE  = 8'hFB;
    localparam logic [7:0] STATUS_STOP      = 8'hFC;
    localparam logic [7:0] STATUS_RSV_FD    = 8'hFD;
    localparam logic [7:0] STATUS_RESET     = 8'hFF;
    localparam logic [7:0] CHANNEL_LIMIT    = 8'hEF;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        mbsp_kind_t  kind;
        logic [7:0]  status;
        logic [3:0]  channel;
        logic [6:0]  first;
        logic [6:0]  second;
        logic [13:0] wide;
        logic        last;
    } mbsp_event_t;

    typedef struct packed {
        logic [1:0]  count;
        mbsp_event_t ev_a;
        mbsp_event_t ev_b;
    } mbsp_dec_t;

endpackage

`default_nettype wire

// File: src/mbsp_decode.sv
// ---------------------------------------------------------------------------
// MIDI message decoder
// Holds the open message state and turns one byte into up to two events.
// ---------------------------------------------------------------------------
`default_nettype none

module mbsp_decode #(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic [7:0]       byte_val,
    output mbsp_pkg::mbsp_dec_t   dec
);
    import mbsp_pkg::*;

    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic [7:0]    open_reg, open_next;
    logic [3:0]    chan_reg, chan_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] count_inc;
    logic [6:0]    held_reg [2];
    logic          held_we;
    logic [6:0]    d0, d1;
    logic          flush_hit, main_hit;
    mbsp_event_t   flush_ev, main_ev;

    assign count_inc = count_reg + CW'(1);
    assign d0 = (count_reg == '0) ? byte_val[6:0] : held_reg[0];
    assign d1 = (count_reg == CW'(1)) ? byte_val[6:0] : held_reg[1];

    always_comb
    begin
        open_next = open_reg;
        chan_next = chan_reg;
        count_next = count_reg;
        held_we = 1'b0;
        flush_hit = 1'b0;
        main_hit = 1'b0;
        flush_ev = '0;
        main_ev = '0;
        if (fire)
        begin
            if (byte_val[7])
            begin
                flush_ev.status = open_reg;
                unique case (open_reg) inside
                    STATUS_SYSEX:
                    begin
                        flush_hit = 1'b1;
                        flush_ev.kind = KIND_SYSEX;
                    end
                    STATUS_RSV_F4, STATUS_RSV_F5, STATUS_RSV_F9, STATUS_RSV_FD:
                    begin
                        flush_hit = 1'b1;
                        flush_ev.kind = KIND_RESERVED;
                    end
                    default:
                    begin
                        flush_hit = 1'b0;
                    end
                endcase
                count_next = '0;
                main_ev.status = byte_val;
                main_ev.last = 1'b1;
                main_hit = 1'b1;
                unique case (byte_val)
                    STATUS_TUNE:     main_ev.kind = KIND_TUNE;
                    STATUS_CLOCK:    main_ev.kind = KIND_CLOCK;
                    STATUS_START:    main_ev.kind = KIND_START;
                    STATUS_CONTINUE: main_ev.kind = KIND_CONTINUE;
                    STATUS_STOP:     main_ev.kind = KIND_STOP;
                    STATUS_RESET:    main_ev.kind = KIND_RESET;
                    default:         main_hit = 1'b0;
                endcase
                if (byte_val > CHANNEL_LIMIT)
                begin
                    open_next = main_hit ? STATUS_NONE : byte_val;
                    chan_next = 4'h0;
                end
                else
                begin
                    open_next = {byte_val[7:4], 4'h0};
                    chan_next = byte_val[3:0];
                end
                flush_ev.last = !main_hit;
            end
            else if (count_reg < CW'(BUFFER_DEPTH))
            begin
                held_we = (count_reg < CW'(2));
                count_next = count_inc;
                main_ev.status = open_reg;
                main_ev.last = 1'b1;
                unique case (open_reg) inside
                    STATUS_NOTE_OFF, STATUS_NOTE_ON, STATUS_POLY, STATUS_CONTROL:
                    begin
                        main_hit = (count_inc == CW'(2));
                        main_ev.kind = mbsp_kind_t'({2'b00, open_reg[6:4]});
                        main_ev.channel = chan_reg;
                        main_ev.first = d0;
                        main_ev.second = d1;
                    end
                    STATUS_PROGRAM, STATUS_CHAN_PRS:
                    begin
                        main_hit = (count_inc == CW'(1));
                        main_ev.kind = mbsp_kind_t'({2'b00, open_reg[6:4]});
                        main_ev.channel = chan_reg;
                        main_ev.first = d0;
                    end
                    STATUS_BEND:
                    begin
                        main_hit = (count_inc == CW'(2));
                        main_ev.kind = KIND_BEND;
                        main_ev.channel = chan_reg;
                        main_ev.first = d0;
                        main_ev.second = d1;
                        main_ev.wide = {d1, d0};
                    end
                    STATUS_TIME_CODE:
                    begin
                        main_hit = (count_inc == CW'(1));
                        main_ev.kind = KIND_TIME_CODE;
                        main_ev.first = {4'h0, d0[6:4]};
                        main_ev.second = {3'h0, d0[3:0]};
                    end
                    STATUS_SONG_POS:
                    begin
                        main_hit = (count_inc == CW'(2));
                        main_ev.kind = KIND_SONG_POS;
                        main_ev.first = d0;
                        main_ev.second = d1;
                        main_ev.wide = {d1, d0};
                    end
                    STATUS_SONG_SEL:
                    begin
                        main_hit = (count_inc == CW'(1));
                        main_ev.kind = KIND_SONG_SEL;
                        main_ev.first = d0;
                    end
                    default:
                    begin
                        main_hit = 1'b0;
                    end
                endcase
                if (main_hit)
                begin
                    open_next = STATUS_NONE;
                    count_next = '0;
                end
            end
            else
            begin
                main_hit = 1'b1;
                main_ev.kind = KIND_BUFFER_FULL;
                main_ev.last = 1'b1;
            end
        end
    end

    always_comb
    begin
        dec.count = {1'b0, flush_hit} + {1'b0, main_hit};
        dec.ev_a = flush_hit ? flush_ev : main_ev;
        dec.ev_b = main_ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= STATUS_NONE;
            chan_reg <= 4'h0;
            count_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
            chan_reg <= chan_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (held_we)
        begin
            held_reg[count_reg[0]] <= byte_val[6:0];
        end
    end

endmodule

`default_nettype wire

// File: src/midi_byte_stream_parser.sv
// ---------------------------------------------------------------------------
// MIDI byte stream parser
// Decodes raw MIDI bytes into one event per complete message or overflowing data byte.
// ---------------------------------------------------------------------------
// Input channel: one MIDI byte per transaction on byte_in, taken when
// in_valid is high and in_stall is low. Output channel: one event per
// transaction, taken when out_valid is high and out_stall is low.
// A byte is taken into an input register, decoded against the open message
// state once at least two queue entries are free, and its events written to a
// four-entry event queue whose head drives the output ports. The input
// register and the event queue lie between a byte and its first event on the
// outputs. Throughput is one byte per cycle while each byte gives at most one
// event and the receiver does not stall; the output side drains one event per
// cycle while out_stall is low, so once the queue backs up a byte that gives
// two events holds the input back.
// A status byte that closes a pending SysEx or reserved message and is itself
// a clock, start, continue, stop, reset or tune request message gives two
// events; last marks the final event of a byte.
// When the receiver stalls, the head event holds and the queue fills; the
// input stalls once fewer than two queue entries are free.
// Reset clears the queue, the input register and the open message.
// ---------------------------------------------------------------------------
`default_nettype none

module midi_byte_stream_parser #(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           byte_in,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output mbsp_pkg::mbsp_kind_t      event_kind,
    output logic [7:0]                status_code,
    output logic [3:0]                channel_num,
    output logic [6:0]                first_data,
    output logic [6:0]                second_data,
    output logic [13:0]               wide_value,
    output logic                      last
);
    import mbsp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int QW = $clog2(QUEUE_DEPTH + 1);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              take;
    logic              pop;
    logic              push_any;
    mbsp_dec_t         dec;
    mbsp_event_t       queue_mem [QUEUE_DEPTH];
    mbsp_event_t       head;
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QW-1:0]     count_reg, count_next;

    assign take = in_valid_reg && (count_reg <= QW'(QUEUE_DEPTH - 2));
    assign in_stall = in_valid_reg && !take;
    assign pop = out_valid && !out_stall;
    assign push_any = (dec.count != 2'd0);

    mbsp_decode #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (take),
        .byte_val (in_byte_reg),
        .dec      (dec)
    );

    assign count_next = count_reg + QW'(dec.count) - QW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                in_valid_reg <= 1'b0;
            end
            wr_ptr_reg <= wr_ptr_reg + PW'(dec.count);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= byte_in;
        end
        if (push_any)
        begin
            queue_mem[wr_ptr_reg] <= dec.ev_a;
        end
        if (dec.count == 2'd2)
        begin
            queue_mem[wr_ptr_reg + PW'(1)] <= dec.ev_b;
        end
    end

    assign head = queue_mem[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign event_kind = head.kind;
    assign status_code = head.status;
    assign channel_num = head.channel;
    assign first_data = head.first;
    assign second_data = head.second;
    assign wide_value = head.wide;
    assign last = head.last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QW'(QUEUE_DEPTH))
        else $error("event queue count out of range");

    a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stalled with empty input register");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && count_reg == QW'(1) && !push_any) |=> !out_valid)
        else $error("queue not empty after draining last event");

    a_bufferfull_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind == KIND_BUFFER_FULL) |-> last)
        else $error("buffer full event without last");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (dec.count == 2'd2) |-> (!dec.ev_a.last && dec.ev_b.last))
        else $error("two events from one byte with wrong last marks");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// MIDI byte stream parser testbench
// Drives raw MIDI bytes into the parser and checks every decoded event
// against a cycle-free decoder kept in the testbench. A directed table covers
// field extremes, every message type, flushes, aborts and buffer overflow;
// random well-formed messages with noise, truncation and long SysEx follow.
// Both channels idle at random, and the receiver holds off once for a long
// stretch so that the event queue fills and the input stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
    import mbsp_pkg::*;

    localparam int BUFFER_DEPTH   = 32;
    localparam int RANDOM_BYTES   = 1020;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_REPORTS    = 10;
    localparam mbsp_event_t NO_EVENT = '0;

    typedef struct {
        logic [7:0]  value;
        int          reps;
        bit          known;
        mbsp_event_t want;
    } stim_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  byte_in   = 8'h00;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    mbsp_kind_t  event_kind;
    logic [7:0]  status_code;
    logic [3:0]  channel_num;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [13:0] wide_value;
    logic        last;

    logic [7:0]  open_msg   = STATUS_NONE;
    logic [3:0]  open_chan  = 4'h0;
    logic [6:0]  held [2]   = '{7'h00, 7'h00};
    int          held_count = 0;

    mbsp_event_t byte_events [$];
    mbsp_event_t awaited_events [$];
    int          bytes_sent   = 0;
    int          error_count  = 0;
    int          quiet_cycles = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    bit          calm         = 1'b0;

    stim_row_t directed_rows [46] = '{
        '{8'h55, 32, 1'b0, NO_EVENT},
        '{8'h7F, 1, 1'b1, '{KIND_BUFFER_FULL, 8'h00, 4'h0, 7'h00, 7'h00, 14'h0000, 1'b1}},
        '{8'h00, 1, 1'b1, '{KIND_BUFFER_FULL, 8'h00, 4'h0, 7'h00, 7'h00, 14'h0000, 1'b1}},
        '{8'h90, 1, 1'b0, NO_EVENT},
        '{8'h00, 1, 1'b0, NO_EVENT},
        '{8'h7F, 1, 1'b1, '{KIND_NOTE_ON, 8'h90, 4'h0, 7'h00, 7'h7F, 14'h0000, 1'b1}},
        '{8'h8F, 1, 1'b0, NO_EVENT},
        '{8'h7F, 1, 1'b0, NO_EVENT},
        '{8'h00, 1, 1'b1, '{KIND_NOTE_OFF, 8'h80, 4'hF, 7'h7F, 7'h00, 14'h0000, 1'b1}},
        '{8'hA5, 1, 1'b0, NO_EVENT},
        '{8'h2A, 2, 1'b0, NO_EVENT},
        '{8'hB9, 1, 1'b0, NO_EVENT},
        '{8'h40, 1, 1'b0, NO_EVENT},
        '{8'h41, 1, 1'b0, NO_EVENT},
        '{8'hC3, 1, 1'b0, NO_EVENT},
        '{8'h15, 1, 1'b0, NO_EVENT},
        '{8'hD0, 1, 1'b0, NO_EVENT},
        '{8'h66, 1, 1'b0, NO_EVENT},
        '{8'hC0, 1, 1'b0, NO_EVENT},
        '{8'hE1, 1, 1'b0, NO_EVENT},
        '{8'h7F, 1, 1'b0, NO_EVENT},
        '{8'h7F, 1, 1'b1, '{KIND_BEND, 8'hE0, 4'h1, 7'h7F, 7'h7F, 14'h3FFF, 1'b1}},
        '{8'hF1, 1, 1'b0, NO_EVENT},
        '{8'h7F, 1, 1'b1, '{KIND_TIME_CODE, 8'hF1, 4'h0, 7'h07, 7'h0F, 14'h0000, 1'b1}},
        '{8'hF2, 1, 1'b0, NO_EVENT},
        '{8'h01, 1, 1'b0, NO_EVENT},
        '{8'h02, 1, 1'b0, NO_EVENT},
        '{8'hF3, 1, 1'b0, NO_EVENT},
        '{8'h09, 1, 1'b0, NO_EVENT},
        '{8'hF0, 1, 1'b0, NO_EVENT},
        '{8'h11, 3, 1'b0, NO_EVENT},
        '{8'hF8, 1, 1'b0, NO_EVENT},
        '{8'hF7, 1, 1'b0, NO_EVENT},
        '{8'h22, 1, 1'b0, NO_EVENT},
        '{8'hFE, 1, 1'b0, NO_EVENT},
        '{8'hF4, 1, 1'b0, NO_EVENT},
        '{8'hF6, 1, 1'b0, NO_EVENT},
        '{8'hF5, 1, 1'b0, NO_EVENT},
        '{8'hF9, 1, 1'b0, NO_EVENT},
        '{8'hFD, 1, 1'b0, NO_EVENT},
        '{8'hFA, 1, 1'b0, NO_EVENT},
        '{8'hFB, 1, 1'b1, '{KIND_CONTINUE, 8'hFB, 4'h0, 7'h00, 7'h00, 14'h0000, 1'b1}},
        '{8'hFC, 1, 1'b1, '{KIND_STOP, 8'hFC, 4'h0, 7'h00, 7'h00, 14'h0000, 1'b1}},
        '{8'hFF, 1, 1'b1, '{KIND_RESET, 8'hFF, 4'h0, 7'h00, 7'h00, 14'h0000, 1'b1}},
        '{8'hF8, 1, 1'b1, '{KIND_CLOCK, 8'hF8, 4'h0, 7'h00, 7'h00, 14'h0000, 1'b1}},
        '{8'h00, 1, 1'b0, NO_EVENT}
    };

    midi_byte_stream_parser #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .byte_in(byte_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_kind(event_kind),
        .status_code(status_code),
        .channel_num(channel_num),
        .first_data(first_data),
        .second_data(second_data),
        .wide_value(wide_value),
        .last(last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit close_message(input bit end_of_msg, output mbsp_event_t ev);
        logic [6:0] d0;
        logic [6:0] d1;
        bit         hit;
        d0 = held[0];
        d1 = held[1];
        ev = NO_EVENT;
        ev.status = open_msg;
        case (open_msg)
            STATUS_NOTE_OFF, STATUS_NOTE_ON, STATUS_POLY, STATUS_CONTROL, STATUS_BEND:
            begin
                hit = (held_count == 2);
                ev.kind = mbsp_kind_t'({2'b00, open_msg[6:4]});
                ev.channel = open_chan;
                ev.first = d0;
                ev.second = d1;
                if (open_msg == STATUS_BEND)
                begin
                    ev.wide = {d1, d0};
                end
            end
            STATUS_PROGRAM, STATUS_CHAN_PRS:
            begin
                hit = (held_count == 1);
                ev.kind = mbsp_kind_t'({2'b00, open_msg[6:4]});
                ev.channel = open_chan;
                ev.first = d0;
            end
            STATUS_SYSEX:
            begin
                hit = end_of_msg;
                ev.kind = KIND_SYSEX;
            end
            STATUS_TIME_CODE:
            begin
                hit = (held_count == 1);
                ev.kind = KIND_TIME_CODE;
                ev.first = {4'b0000, d0[6:4]};
                ev.second = {3'b000, d0[3:0]};
            end
            STATUS_SONG_POS:
            begin
                hit = (held_count == 2);
                ev.kind = KIND_SONG_POS;
                ev.first = d0;
                ev.second = d1;
                ev.wide = {d1, d0};
            end
            STATUS_SONG_SEL:
            begin
                hit = (held_count == 1);
                ev.kind = KIND_SONG_SEL;
                ev.first = d0;
            end
            STATUS_RSV_F4, STATUS_RSV_F5, STATUS_RSV_F9, STATUS_RSV_FD:
            begin
                hit = end_of_msg;
                ev.kind = KIND_RESERVED;
            end
            STATUS_TUNE:
            begin
                hit = 1'b1;
                ev.kind = KIND_TUNE;
            end
            STATUS_CLOCK:
            begin
                hit = 1'b1;
                ev.kind = KIND_CLOCK;
            end
            STATUS_START:
            begin
                hit = 1'b1;
                ev.kind = KIND_START;
            end
            STATUS_CONTINUE:
            begin
                hit = 1'b1;
                ev.kind = KIND_CONTINUE;
            end
            STATUS_STOP:
            begin
                hit = 1'b1;
                ev.kind = KIND_STOP;
            end
            STATUS_RESET:
            begin
                hit = 1'b1;
                ev.kind = KIND_RESET;
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
        if (hit)
        begin
            open_msg = STATUS_NONE;
            held_count = 0;
        end
        return hit;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        mbsp_event_t ev;
        byte_events.delete();
        if (b[7])
        begin
            if (open_msg != STATUS_NONE)
            begin
                if (close_message(1'b1, ev))
                begin
                    byte_events.push_back(ev);
                end
            end
            held_count = 0;
            if (b > CHANNEL_LIMIT)
            begin
                open_msg = b;
                open_chan = 4'h0;
            end
            else
            begin
                open_msg = {b[7:4], 4'h0};
                open_chan = b[3:0];
            end
            if (close_message(1'b0, ev))
            begin
                byte_events.push_back(ev);
            end
        end
        else if (held_count < BUFFER_DEPTH)
        begin
            if (held_count < 2)
            begin
                held[held_count] = b[6:0];
            end
            held_count++;
            if (close_message(1'b0, ev))
            begin
                byte_events.push_back(ev);
            end
        end
        else
        begin
            ev = NO_EVENT;
            ev.kind = KIND_BUFFER_FULL;
            byte_events.push_back(ev);
        end
        if (byte_events.size() > 0)
        begin
            byte_events[byte_events.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic string show_event(input mbsp_event_t e);
        return $sformatf("kind=%0d status=%h ch=%0d first=%0d second=%0d wide=%0d last=%0d",
                         e.kind, e.status, e.channel, e.first, e.second, e.wide, e.last);
    endfunction

    function automatic void record_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit known = 1'b0,
                             input mbsp_event_t want = NO_EVENT);
        while (!calm && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in <= b;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        decode_byte(b);
        if (known)
        begin
            awaited_events.push_back(want);
        end
        else
        begin
            foreach (byte_events[i])
            begin
                awaited_events.push_back(byte_events[i]);
            end
        end
        bytes_sent++;
        calm <= (bytes_sent >= 600 && bytes_sent < 800);
    endtask

    task automatic send_message();
        logic [7:0] status;
        int         needed;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            send_byte(8'($urandom_range(255)));
            return;
        end
        if (pick < 70)
        begin
            status = 8'($urandom_range(8'hEF, 8'h80));
        end
        else
        begin
            status = 8'($urandom_range(8'hFF, 8'hF0));
        end
        if (status <= CHANNEL_LIMIT)
        begin
            needed = (status[7:4] == STATUS_PROGRAM[7:4] || status[7:4] == STATUS_CHAN_PRS[7:4])
                     ? 1 : 2;
        end
        else
        begin
            case (status)
                STATUS_TIME_CODE, STATUS_SONG_SEL: needed = 1;
                STATUS_SONG_POS: needed = 2;
                STATUS_SYSEX:
                begin
                    needed = ($urandom_range(99) < 6) ? $urandom_range(40, 30)
                                                      : $urandom_range(8);
                end
                STATUS_RSV_F4, STATUS_RSV_F5, STATUS_RSV_F9, STATUS_RSV_FD: needed = $urandom_range(3);
                default: needed = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
            endcase
        end
        pick = $urandom_range(99);
        if (pick < 10 && needed > 0)
        begin
            needed = $urandom_range(needed - 1);
        end
        else if (pick < 15)
        begin
            needed += 1 + $urandom_range(2);
        end
        send_byte(status);
        repeat (needed)
        begin
            send_byte({1'b0, 7'($urandom_range(127))});
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && bytes_sent >= 300)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(99) < 17);
        end
    end

    always @(posedge clk)
    begin : check_events
        mbsp_event_t got;
        mbsp_event_t want;
        if (out_valid && !out_stall)
        begin
            got.kind = event_kind;
            got.status = status_code;
            got.channel = channel_num;
            got.first = first_data;
            got.second = second_data;
            got.wide = wide_value;
            got.last = last;
            if (awaited_events.size() == 0)
            begin
                record_error({"unexpected event: ", show_event(got)});
            end
            else
            begin
                want = awaited_events.pop_front();
                if (got !== want)
                begin
                    record_error({"event mismatch: expected ", show_event(want),
                                  " actual ", show_event(got)});
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : run
        int random_start;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed_rows[r])
        begin
            repeat (directed_rows[r].reps)
            begin
                send_byte(directed_rows[r].value, directed_rows[r].known, directed_rows[r].want);
            end
        end
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            send_message();
        end
        in_valid <= 1'b0;
        while (awaited_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (error_count == 0 && awaited_events.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
